### hdl/jetc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package jetc_pkg;

  // Sample and register width (two's complement)
  localparam int SAMPLE_WIDTH = 16;
  localparam int IN_TDATA_W   = ((SAMPLE_WIDTH + 7) / 8) * 8;

  // Color channel widths
  localparam int CH_W        = 8;
  localparam int OUT_TDATA_W = 3 * CH_W;

  // Fixed point: normalized position in Q.12
  localparam int FRAC_BITS = 12;
  localparam int Q_ONE     = 1 << FRAC_BITS;
  localparam int Q_HALF    = Q_ONE / 2;
  localparam int Q_1_4     = Q_ONE / 4;
  localparam int Q_1_8     = Q_ONE / 8;
  localparam int Q_3_8     = (3 * Q_ONE) / 8;

  // |u| < 1/2, so the quotient magnitude needs FRAC_BITS-1 bits
  localparam int QUO_BITS = FRAC_BITS - 1;
  localparam int U_W      = FRAC_BITS + 1;  // signed u
  localparam int X_W      = FRAC_BITS + 2;  // signed channel argument and taps
  localparam int S_W      = X_W + 3;        // signed hat-function sum
  localparam int C_W      = FRAC_BITS + 1;  // clamped intensity, 0..Q_ONE

  // Saturated channel level for out-of-range samples
  localparam logic [CH_W-1:0] CH_HALF = CH_W'(1 << (CH_W - 1));

  // Configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_LOWER = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_UPPER = CFG_IDX_W'(1);

  // Flags that travel with each sample down the pipeline
  typedef struct packed {
    logic vld;     // stage holds a sample
    logic neg;     // normalized position is negative
    logic sat_hi;  // sample at or above upper bound
    logic sat_lo;  // sample at or below lower bound
  } jetc_side_t;

  // Result word, red in the low byte
  typedef struct packed {
    logic [CH_W-1:0] blue;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] red;
  } jetc_rgb_t;

endpackage

`default_nettype wire

### hdl/jetc_div.sv
`timescale 1ns / 1ps
`default_nettype none

// Pipelined restoring divider: quo = floor(num * 2^QUO_BITS / den), num < den.
// One quotient bit per stage, QUO_BITS stages; all stages advance on en.
module jetc_div (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              en,
  input  jetc_pkg::jetc_side_t              side_in,
  input  logic [jetc_pkg::SAMPLE_WIDTH-1:0] num_in,
  input  logic [jetc_pkg::SAMPLE_WIDTH-1:0] den_in,
  output jetc_pkg::jetc_side_t              side_out,
  output logic [jetc_pkg::QUO_BITS-1:0]     quo_out
);
  import jetc_pkg::*;

  jetc_side_t              side_r [QUO_BITS];
  logic [SAMPLE_WIDTH-1:0] rem_r  [QUO_BITS];
  logic [SAMPLE_WIDTH-1:0] den_r  [QUO_BITS];
  logic [QUO_BITS-1:0]     quo_r  [QUO_BITS];
  logic [SAMPLE_WIDTH-1:0] rem_nxt [QUO_BITS];
  logic [QUO_BITS-1:0]     quo_nxt [QUO_BITS];

  for (genvar k = 0; k < QUO_BITS; k++) begin : g_step
    logic [SAMPLE_WIDTH-1:0] rem_src;
    logic [SAMPLE_WIDTH-1:0] den_src;
    logic [QUO_BITS-1:0]     quo_src;
    jetc_side_t              side_src;
    logic [SAMPLE_WIDTH:0]   dbl;
    logic [SAMPLE_WIDTH:0]   dif;
    logic                    ge;

    if (k == 0) begin : g_first
      assign rem_src  = num_in;
      assign den_src  = den_in;
      assign quo_src  = '0;
      assign side_src = side_in;
    end else begin : g_next
      assign rem_src  = rem_r[k-1];
      assign den_src  = den_r[k-1];
      assign quo_src  = quo_r[k-1];
      assign side_src = side_r[k-1];
    end

    // Shift remainder, trial subtract, keep if it fits
    assign dbl = {rem_src, 1'b0};
    assign ge  = (dbl >= {1'b0, den_src});
    assign dif = dbl - {1'b0, den_src};
    assign rem_nxt[k] = ge ? dif[SAMPLE_WIDTH-1:0] : dbl[SAMPLE_WIDTH-1:0];
    assign quo_nxt[k] = {quo_src[QUO_BITS-2:0], ge};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        side_r[k] <= '0;
      end else if (en) begin
        side_r[k] <= side_src;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= rem_nxt[k];
        den_r[k] <= den_src;
        quo_r[k] <= quo_nxt[k];
      end
    end
  end

  assign side_out = side_r[QUO_BITS-1];
  assign quo_out  = quo_r[QUO_BITS-1];

endmodule

`default_nettype wire

### hdl/value_to_jet_color.sv
`timescale 1ns / 1ps
`default_nettype none
// Jet false-color mapper: one signed sample in, one RGB triple out.
// Throughput: one sample per cycle, sustained while out_tready stays high.
// The normalized position is formed by the 11-stage bit-per-stage divider.
// Reset (synchronous, rst_n low): pipeline emptied, lower bound 0, upper bound max positive.
module value_to_jet_color (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // input stream
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [jetc_pkg::IN_TDATA_W-1:0]      in_tdata,   // [15:0] sample_value
  // result stream
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [jetc_pkg::OUT_TDATA_W-1:0]     out_tdata,  // [7:0] red, [15:8] green,
                                                           // [23:16] blue
  // configuration writes
  input  logic                                 cfg_we,
  input  logic [jetc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [jetc_pkg::SAMPLE_WIDTH-1:0]    cfg_wdata
);
  import jetc_pkg::*;

  localparam int TAP_OFF [4] = '{Q_3_8, Q_1_8, -Q_1_8, -Q_3_8};

  // Bound registers
  logic signed [SAMPLE_WIDTH-1:0] lo_r;
  logic signed [SAMPLE_WIDTH-1:0] hi_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lo_r <= '0;
      hi_r <= {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_LOWER: lo_r <= cfg_wdata;
        CFG_UPPER: hi_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Pipeline advance: stalls only when the skid register is occupied
  logic skid_v_r;
  logic en;
  assign en        = !skid_v_r;
  assign in_tready = en;

  // Stage 1: centered numerator, span, range flags
  logic signed [SAMPLE_WIDTH-1:0] samp;
  logic signed [SAMPLE_WIDTH+1:0] sum_nxt;
  logic [SAMPLE_WIDTH-1:0]        span_nxt;
  jetc_side_t                     s1_side_nxt;
  jetc_side_t                     s1_side_r;
  logic signed [SAMPLE_WIDTH+1:0] s1_sum_r;
  logic [SAMPLE_WIDTH-1:0]        s1_span_r;

  assign samp     = $signed(in_tdata[SAMPLE_WIDTH-1:0]);
  assign sum_nxt  = {samp[SAMPLE_WIDTH-1], samp, 1'b0}
                  - {{2{hi_r[SAMPLE_WIDTH-1]}}, hi_r}
                  - {{2{lo_r[SAMPLE_WIDTH-1]}}, lo_r};
  assign span_nxt = SAMPLE_WIDTH'(hi_r - lo_r);

  always_comb begin
    s1_side_nxt        = '0;
    s1_side_nxt.vld    = in_tvalid;
    s1_side_nxt.sat_hi = (samp >= hi_r);
    s1_side_nxt.sat_lo = (samp <= lo_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_side_r <= '0;
    end else if (en) begin
      s1_side_r <= s1_side_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_sum_r  <= sum_nxt;
      s1_span_r <= span_nxt;
    end
  end

  // Stage 2: sign and magnitude of numerator
  jetc_side_t              s2_side_nxt;
  jetc_side_t              s2_side_r;
  logic [SAMPLE_WIDTH-1:0] s2_num_nxt;
  logic [SAMPLE_WIDTH-1:0] s2_num_r;
  logic [SAMPLE_WIDTH-1:0] s2_den_r;

  always_comb begin
    s2_side_nxt     = s1_side_r;
    s2_side_nxt.neg = s1_sum_r[SAMPLE_WIDTH+1];
    s2_num_nxt      = s1_sum_r[SAMPLE_WIDTH+1] ? SAMPLE_WIDTH'(-s1_sum_r)
                                               : s1_sum_r[SAMPLE_WIDTH-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_side_r <= '0;
    end else if (en) begin
      s2_side_r <= s2_side_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_num_r <= s2_num_nxt;
      s2_den_r <= s1_span_r;
    end
  end

  // Divider: |u| = floor(|num| * 2^11 / span)
  jetc_side_t          dv_side;
  logic [QUO_BITS-1:0] dv_quo;

  jetc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .side_in  (s2_side_r),
    .num_in   (s2_num_r),
    .den_in   (s2_den_r),
    .side_out (dv_side),
    .quo_out  (dv_quo)
  );

  // Stage 3: signed position u (truncated toward zero)
  logic [U_W-1:0]        u_mag;
  logic signed [U_W-1:0] u_nxt;
  logic signed [U_W-1:0] u_r;
  jetc_side_t            s3_side_r;

  assign u_mag = {{(U_W-QUO_BITS){1'b0}}, dv_quo};
  assign u_nxt = dv_side.neg ? $signed(U_W'(-u_mag)) : $signed(u_mag);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_side_r <= '0;
    end else if (en) begin
      s3_side_r <= dv_side;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      u_r <= u_nxt;
    end
  end

  // Stages 4-6, per channel: red at u-1/4, green at u, blue at u+1/4
  logic signed [X_W-1:0] u_ext;
  logic [X_W-1:0]        tap_r   [3][4];
  logic [C_W-1:0]        lvl_r   [3];
  logic [CH_W-1:0]       chan    [3];
  jetc_side_t            s4_side_r;
  jetc_side_t            s5_side_r;

  assign u_ext = {{(X_W-U_W){u_r[U_W-1]}}, u_r};

  for (genvar ch = 0; ch < 3; ch++) begin : g_chan
    localparam int OFF = (ch - 1) * Q_1_4;
    logic signed [X_W-1:0] x;
    logic signed [S_W-1:0] hat;
    logic [C_W-1:0]        lvl_nxt;
    logic [C_W+CH_W-1:0]   scaled;

    assign x = u_ext + $signed(X_W'(OFF));

    // Stage 4: distances to the four breakpoints
    for (genvar j = 0; j < 4; j++) begin : g_tap
      logic signed [X_W-1:0] t;
      assign t = x + $signed(X_W'(TAP_OFF[j]));
      always_ff @(posedge clk) begin
        if (en) begin
          tap_r[ch][j] <= t[X_W-1] ? X_W'(-t) : t;
        end
      end
    end

    // Stage 5: hat function, clamped to [0, 1]
    assign hat = ($signed({3'b000, tap_r[ch][0]}) - $signed({3'b000, tap_r[ch][1]})
                - $signed({3'b000, tap_r[ch][2]}) + $signed({3'b000, tap_r[ch][3]})) <<< 1;

    always_comb begin
      if (hat[S_W-1]) begin
        lvl_nxt = '0;
      end else if (hat > $signed(S_W'(Q_ONE))) begin
        lvl_nxt = C_W'(Q_ONE);
      end else begin
        lvl_nxt = hat[C_W-1:0];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        lvl_r[ch] <= lvl_nxt;
      end
    end

    // Scale to 0..255 with rounding: (c*255 + 1/2) >> 12
    assign scaled   = {lvl_r[ch], {CH_W{1'b0}}} - {{CH_W{1'b0}}, lvl_r[ch]}
                    + (C_W+CH_W)'(Q_HALF);
    assign chan[ch] = scaled[FRAC_BITS+CH_W-1:FRAC_BITS];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_side_r <= '0;
      s5_side_r <= '0;
    end else if (en) begin
      s4_side_r <= s3_side_r;
      s5_side_r <= s4_side_r;
    end
  end

  // Stage 6: final color, out-of-range samples override
  jetc_rgb_t rgb_nxt;
  jetc_rgb_t s6_rgb_r;
  logic      s6_v_r;

  always_comb begin
    if (s5_side_r.sat_hi) begin
      rgb_nxt.red   = CH_HALF;
      rgb_nxt.green = '0;
      rgb_nxt.blue  = '0;
    end else if (s5_side_r.sat_lo) begin
      rgb_nxt.red   = '0;
      rgb_nxt.green = '0;
      rgb_nxt.blue  = CH_HALF;
    end else begin
      rgb_nxt.red   = chan[0];
      rgb_nxt.green = chan[1];
      rgb_nxt.blue  = chan[2];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s6_v_r <= 1'b0;
    end else if (en) begin
      s6_v_r <= s5_side_r.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s6_rgb_r <= rgb_nxt;
    end
  end

  // Output register plus skid register; stage 6 empties whenever en is high
  logic      out_v_r;
  jetc_rgb_t out_d_r;
  jetc_rgb_t skid_d_r;
  logic      take;

  assign take = !out_v_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (take) begin
      if (skid_v_r) begin
        out_v_r  <= 1'b1;
        skid_v_r <= 1'b0;
      end else begin
        out_v_r  <= s6_v_r;
      end
    end else if (!skid_v_r) begin
      skid_v_r <= s6_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_d_r <= skid_v_r ? skid_d_r : s6_rgb_r;
    end
    if (!take && !skid_v_r) begin
      skid_d_r <= s6_rgb_r;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_d_r;

endmodule

`default_nettype wire
